@@ src/ipst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_pkg
// Shared types and constants of the hashed IPv4/IPv6 address set.
// ----------------------------------------------------------------------------
package ipst_pkg;

	localparam int ADDR_W  = 64;
	localparam int TOTAL_W = 11;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_FLUSH  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_PRESENT = 2'd1,
		STATUS_ABSENT  = 2'd2,
		STATUS_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOCATE,
		S_COMPARE,
		S_FLUSH_RESP
	} state_t;

	// one way of a bucket row
	typedef struct packed {
		logic              valid;
		logic              family;
		logic [ADDR_W-1:0] addr_high;
		logic [ADDR_W-1:0] addr_low;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic in_ready;
		logic hash_step;
		logic rd_en;
		logic commit;
		logic clear_write;
		logic flush_done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_fire;
		logic in_flush;
		logic hash_done;
		logic clear_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ src/ipst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_if
// Request and response channels of the address set (valid/ready).
// ----------------------------------------------------------------------------
interface ipst_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic                       family;
	logic [ipst_pkg::ADDR_W-1:0] addr_high;
	logic [ipst_pkg::ADDR_W-1:0] addr_low;

	modport source (output valid, kind, family, addr_high, addr_low, input ready);
	modport sink   (input valid, kind, family, addr_high, addr_low, output ready);
endinterface

interface ipst_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [ipst_pkg::TOTAL_W-1:0] entry_total;

	modport source (output valid, status, entry_total, input ready);
	modport sink   (input valid, status, entry_total, output ready);
endinterface

@@ src/ipst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/ipst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_ctrl
// Sequencer: clear sweep, bucket locate, row compare/write-back, response.
// ----------------------------------------------------------------------------
module ipst_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipst_pkg::ctrl_sts_t   sts,
	output ipst_pkg::ctrl_cmd_t   cmd
);

	ipst_pkg::state_t state_q, state_d;
	logic             flush_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ipst_pkg::S_CLEAR;
			flush_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sts.in_fire && sts.in_flush) begin
				flush_pend_q <= 1'b1;
			end else if (cmd.flush_done) begin
				flush_pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipst_pkg::S_CLEAR: begin
				if (sts.clear_last) begin
					state_d = flush_pend_q ? ipst_pkg::S_FLUSH_RESP : ipst_pkg::S_IDLE;
				end
			end
			ipst_pkg::S_IDLE: begin
				if (sts.in_fire) begin
					state_d = sts.in_flush ? ipst_pkg::S_CLEAR : ipst_pkg::S_LOCATE;
				end
			end
			ipst_pkg::S_LOCATE: begin
				if (sts.hash_done) begin
					state_d = ipst_pkg::S_COMPARE;
				end
			end
			ipst_pkg::S_COMPARE: begin
				if (sts.out_free) begin
					state_d = ipst_pkg::S_IDLE;
				end
			end
			ipst_pkg::S_FLUSH_RESP: begin
				if (sts.out_free) begin
					state_d = ipst_pkg::S_IDLE;
				end
			end
			default: state_d = ipst_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ipst_pkg::S_CLEAR:      cmd.clear_write = 1'b1;
			ipst_pkg::S_IDLE:       cmd.in_ready    = 1'b1;
			ipst_pkg::S_LOCATE: begin
				cmd.rd_en     = sts.hash_done;
				cmd.hash_step = !sts.hash_done;
			end
			ipst_pkg::S_COMPARE:    cmd.commit      = sts.out_free;
			ipst_pkg::S_FLUSH_RESP: cmd.flush_done  = sts.out_free;
			default:                cmd = '0;
		endcase
	end

endmodule

@@ src/ipst_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_datapath
// Item registers, bucket hash, bucket-row RAM, way compare and result register.
// ----------------------------------------------------------------------------
module ipst_datapath #(
	parameter int NUM_BUCKETS = 256,
	parameter int WAYS        = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	ipst_req_if.sink            req,
	ipst_rsp_if.source          rsp,
	input  ipst_pkg::ctrl_cmd_t cmd,
	output ipst_pkg::ctrl_sts_t sts
);

	localparam int  BW    = $clog2(NUM_BUCKETS);
	localparam int  WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int  CW    = $clog2(NUM_BUCKETS * WAYS + 1);
	localparam int  ROW_W = WAYS * ipst_pkg::SLOT_W;
	localparam bit  POW2  = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

	logic                          in_fire;
	logic [ipst_pkg::ADDR_W-1:0]   in_hi, in_lo;
	logic [31:0]                   in_fold;

	ipst_pkg::kind_t               kind_q;
	logic                          fam_q;
	logic [ipst_pkg::ADDR_W-1:0]   hi_q, lo_q;

	logic [BW-1:0]                 bucket;
	logic                          hash_done;
	logic [BW-1:0]                 clr_ptr_q;
	logic [CW-1:0]                 count_q, count_next;

	logic                          ram_we;
	logic [BW-1:0]                 ram_waddr;
	logic [ROW_W-1:0]              ram_wdata, ram_rdata;
	ipst_pkg::slot_t [WAYS-1:0]    row_cur, row_new;
	logic                          row_write;

	logic                          hit_any, free_any;
	logic [WW-1:0]                 hit_idx, free_idx;
	ipst_pkg::status_t             res_status;

	logic                          out_valid_q;
	ipst_pkg::status_t             out_status_q;
	logic [ipst_pkg::TOTAL_W-1:0]  out_total_q;

	assign req.ready = cmd.in_ready;
	assign in_fire   = req.valid && cmd.in_ready;

	// IPv4 upper bits are dropped here, so the fold below is one formula
	assign in_hi   = req.family ? req.addr_high : '0;
	assign in_lo   = req.family ? req.addr_low : {32'd0, req.addr_low[31:0]};
	assign in_fold = in_hi[63:32] ^ in_hi[31:0] ^ in_lo[63:32] ^ in_lo[31:0];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= ipst_pkg::kind_t'(req.kind);
			fam_q  <= req.family;
			hi_q   <= in_hi;
			lo_q   <= in_lo;
		end
	end

	generate
		if (POW2) begin : g_mask
			logic [BW-1:0] bucket_q;

			always_ff @(posedge clk) begin
				if (in_fire) begin
					bucket_q <= in_fold[BW-1:0];
				end
			end

			assign bucket    = bucket_q;
			assign hash_done = 1'b1;
		end else begin : g_rem
			// reciprocal estimate of the quotient is low by at most one,
			// so one conditional subtract finishes the remainder; 3 steps
			localparam int          SH    = 32 + BW;
			localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(NUM_BUCKETS);

			logic [31:0]   fold_q;
			logic [31:0]   quot_s1;
			logic [BW:0]   rest_s2;
			logic [BW-1:0] rem_q;
			logic [1:0]    step_q;
			logic [64:0]   prod;
			logic [31:0]   back;

			assign prod = {33'd0, fold_q} * {32'd0, RECIP[32:0]};
			assign back = quot_s1 * 32'(NUM_BUCKETS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
				end else if (in_fire) begin
					step_q <= '0;
				end else if (cmd.hash_step) begin
					step_q <= step_q + 2'd1;
				end
			end

			always_ff @(posedge clk) begin
				if (in_fire) begin
					fold_q <= in_fold;
				end
				if (cmd.hash_step) begin
					quot_s1 <= 32'(prod >> SH);
					rest_s2 <= (BW + 1)'(fold_q - back);
					if (rest_s2 >= (BW + 1)'(NUM_BUCKETS)) begin
						rem_q <= BW'(rest_s2 - (BW + 1)'(NUM_BUCKETS));
					end else begin
						rem_q <= BW'(rest_s2);
					end
				end
			end

			assign bucket    = rem_q;
			assign hash_done = (step_q == 2'd3);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (in_fire) begin
			clr_ptr_q <= '0;
		end else if (cmd.clear_write) begin
			clr_ptr_q <= clr_ptr_q + BW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_write) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_next;
		end
	end

	ipst_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_BUCKETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (cmd.rd_en),
		.rd_addr (bucket),
		.rd_data (ram_rdata)
	);

	assign row_cur   = ram_rdata;
	assign ram_we    = cmd.clear_write || (cmd.commit && row_write);
	assign ram_waddr = cmd.clear_write ? clr_ptr_q : bucket;
	assign ram_wdata = cmd.clear_write ? '0 : row_new;

	// lowest matching way and lowest free way
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_cur[w].valid && row_cur[w].family == fam_q &&
			    row_cur[w].addr_high == hi_q && row_cur[w].addr_low == lo_q) begin
				hit_any = 1'b1;
				hit_idx = WW'(w);
			end
			if (!row_cur[w].valid) begin
				free_any = 1'b1;
				free_idx = WW'(w);
			end
		end
	end

	always_comb begin
		row_new    = row_cur;
		row_write  = 1'b0;
		count_next = count_q;
		res_status = ipst_pkg::STATUS_DONE;
		unique case (kind_q)
			ipst_pkg::KIND_ADD: begin
				if (hit_any) begin
					res_status = ipst_pkg::STATUS_PRESENT;
				end else if (free_any) begin
					row_new[free_idx].valid     = 1'b1;
					row_new[free_idx].family    = fam_q;
					row_new[free_idx].addr_high = hi_q;
					row_new[free_idx].addr_low  = lo_q;
					row_write  = 1'b1;
					count_next = count_q + CW'(1);
				end else begin
					res_status = ipst_pkg::STATUS_FULL;
				end
			end
			ipst_pkg::KIND_DELETE: begin
				if (hit_any) begin
					row_new[hit_idx].valid = 1'b0;
					row_write  = 1'b1;
					count_next = count_q - CW'(1);
				end else begin
					res_status = ipst_pkg::STATUS_ABSENT;
				end
			end
			ipst_pkg::KIND_LOOKUP: begin
				if (!hit_any) begin
					res_status = ipst_pkg::STATUS_ABSENT;
				end
			end
			ipst_pkg::KIND_FLUSH: begin
				count_next = '0;
			end
			default: res_status = ipst_pkg::STATUS_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.flush_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_total_q  <= ipst_pkg::TOTAL_W'(count_next);
		end else if (cmd.flush_done) begin
			out_status_q <= ipst_pkg::STATUS_DONE;
			out_total_q  <= '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_total = out_total_q;

	assign sts.in_fire    = in_fire;
	assign sts.in_flush   = (req.kind == ipst_pkg::KIND_FLUSH);
	assign sts.hash_done  = hash_done;
	assign sts.clear_last = (clr_ptr_q == BW'(NUM_BUCKETS - 1));
	assign sts.out_free   = !out_valid_q || rsp.ready;

endmodule

@@ src/ip_address_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_set_table
// Hashed exact-match set of IPv4/IPv6 addresses: add, delete, lookup, flush.
// ----------------------------------------------------------------------------
//
//  port  dir  payload                               item
//  req   in   kind, family, addr_high, addr_low     one table operation
//  rsp   out  status, entry_total                   one result per operation
//
// Add/delete/lookup, from accept to result when NUM_BUCKETS is a power of
// two: bucket RAM read, then compare and row write-back; other bucket
// counts first take a reciprocal-multiply remainder of the fold.
// Flush and reset both run a clearing pass over every row of the bucket
// RAM, one row per cycle; req.ready stays low meanwhile.
// One operation at a time; the next item is taken while a result waits in
// the output register, and rsp stalls hold the operation after that.
// ----------------------------------------------------------------------------
module ip_address_set_table #(
	parameter int NUM_BUCKETS = 256,
	parameter int WAYS        = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ipst_req_if.sink   req,
	ipst_rsp_if.source rsp
);

	ipst_pkg::ctrl_cmd_t cmd;
	ipst_pkg::ctrl_sts_t sts;

	ipst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ipst_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

@@ src/ipst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipst_checker
// Port-level checks of the address set, bound to the top level.
// ----------------------------------------------------------------------------
module ipst_checker #(
	parameter int SLOT_COUNT = 1024
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [1:0]                   rsp_status,
	input logic [ipst_pkg::TOTAL_W-1:0] rsp_entry_total
);

	logic                         req_fire, rsp_fire;
	logic [1:0]                   pend_q;
	logic                         seen_q;
	logic [ipst_pkg::TOTAL_W-1:0] last_total_q;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			seen_q       <= 1'b0;
			last_total_q <= '0;
		end else begin
			if (req_fire && !rsp_fire) begin
				pend_q <= pend_q + 2'd1;
			end else if (rsp_fire && !req_fire) begin
				pend_q <= pend_q - 2'd1;
			end
			if (rsp_fire) begin
				seen_q       <= 1'b1;
				last_total_q <= rsp_entry_total;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_status) && $stable(rsp_entry_total))
		else $error("rsp payload changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two items in flight");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (SLOT_COUNT > 2047) || (rsp_entry_total <= SLOT_COUNT))
		else $error("entry count above table capacity");

	a_count_kept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire && seen_q && rsp_status != ipst_pkg::STATUS_DONE |->
			rsp_entry_total == last_total_q)
		else $error("entry count moved on a failed operation");

endmodule

bind ip_address_set_table ipst_checker #(
	.SLOT_COUNT (NUM_BUCKETS * WAYS)
) u_ipst_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_total (rsp.entry_total)
);

@@ sim/tb_ip_address_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_address_set_table
// Self-checking bench for the hashed IPv4/IPv6 address set. The bench keeps
// its own copy of the slot table. It predicts status and entry count for
// every accepted operation and checks each response in order. The directed
// tests cover the basic ops, family separation, ignored IPv4 upper bits,
// full buckets and flush. A full-table fill and a random mix of ops over
// hot buckets and reused addresses follow.
// ----------------------------------------------------------------------------
module tb_ip_address_set_table;

	localparam int NUM_BUCKETS = 256;
	localparam int WAYS        = 4;
	localparam int SLOTS       = NUM_BUCKETS * WAYS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP     = 13;
	localparam int POOL_DEPTH  = 48;

	typedef struct packed {
		ipst_pkg::status_t            status;
		logic [ipst_pkg::TOTAL_W-1:0] total;
	} reply_t;

	typedef struct packed {
		logic                        fam;
		logic [ipst_pkg::ADDR_W-1:0] hi;
		logic [ipst_pkg::ADDR_W-1:0] lo;
	} ip_addr_t;

	logic clk;
	logic arst_n;

	ipst_req_if req_if ();
	ipst_rsp_if rsp_if ();

	ip_address_set_table #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS       (WAYS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// shadow of the slot table
	bit                          slot_used [SLOTS];
	bit                          slot_fam  [SLOTS];
	logic [ipst_pkg::ADDR_W-1:0] slot_hi   [SLOTS];
	logic [ipst_pkg::ADDR_W-1:0] slot_lo   [SLOTS];
	int unsigned                 live_total;

	reply_t   pending_replies[$];
	ip_addr_t recent_addrs[$];
	ip_addr_t filled_addrs[$];

	int    error_count;
	int    cycle_count;
	int    rsp_gap;
	bit    burst_mode;
	int    ops_by_kind[4];
	int    replies_by_status[4];
	int    peak_total;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		if (burst_mode)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic reply_t set_apply_op(ipst_pkg::kind_t op, ip_addr_t a);
		logic [ipst_pkg::ADDR_W-1:0] hi;
		logic [ipst_pkg::ADDR_W-1:0] lo;
		logic [31:0]                 fold;
		int                          base;
		int                          hit;
		reply_t                      r;
		hi = a.fam ? a.hi : '0;
		lo = a.fam ? a.lo : {32'd0, a.lo[31:0]};
		fold = a.fam ? (hi[63:32] ^ hi[31:0] ^ lo[63:32] ^ lo[31:0]) : lo[31:0];
		base = int'(fold % NUM_BUCKETS) * WAYS;
		hit = -1;
		r.status = ipst_pkg::STATUS_DONE;
		if (op == ipst_pkg::KIND_FLUSH) begin
			for (int i = 0; i < SLOTS; i++)
				slot_used[i] = 1'b0;
			live_total = 0;
		end else begin
			for (int w = 0; w < WAYS; w++)
				if (hit < 0 && slot_used[base + w] && slot_fam[base + w] == a.fam &&
						slot_hi[base + w] == hi && slot_lo[base + w] == lo)
					hit = w;
			case (op)
				ipst_pkg::KIND_ADD: begin
					if (hit >= 0) begin
						r.status = ipst_pkg::STATUS_PRESENT;
					end else begin
						r.status = ipst_pkg::STATUS_FULL;
						// lowest free way wins
						for (int w = 0; w < WAYS; w++)
							if (r.status == ipst_pkg::STATUS_FULL && !slot_used[base + w]) begin
								slot_used[base + w] = 1'b1;
								slot_fam[base + w]  = a.fam;
								slot_hi[base + w]   = hi;
								slot_lo[base + w]   = lo;
								live_total++;
								r.status = ipst_pkg::STATUS_DONE;
							end
					end
				end
				ipst_pkg::KIND_DELETE: begin
					if (hit >= 0) begin
						slot_used[base + hit] = 1'b0;
						live_total--;
					end else begin
						r.status = ipst_pkg::STATUS_ABSENT;
					end
				end
				default: r.status = (hit >= 0) ? ipst_pkg::STATUS_DONE : ipst_pkg::STATUS_ABSENT;
			endcase
		end
		r.total = ipst_pkg::TOTAL_W'(live_total);
		return r;
	endfunction

	// random address whose fold lands in the given bucket
	function automatic ip_addr_t addr_in_bucket(logic fam, int bucket);
		ip_addr_t    a;
		logic [31:0] fold;
		a.fam = fam;
		a.hi  = {$urandom, $urandom};
		a.lo  = {$urandom, $urandom};
		if (!fam) begin
			a.lo[7:0] = bucket[7:0];
		end else begin
			fold = a.hi[63:32] ^ a.hi[31:0] ^ a.lo[63:32] ^ a.lo[31:0];
			a.lo[7:0] = a.lo[7:0] ^ fold[7:0] ^ bucket[7:0];
		end
		return a;
	endfunction

	// IPv4 bits outside 31:0 are don't-care; give them fresh junk on reuse
	function automatic ip_addr_t scramble_unused(ip_addr_t a);
		ip_addr_t b;
		b = a;
		if (!b.fam) begin
			b.hi        = {$urandom, $urandom};
			b.lo[63:32] = $urandom;
		end
		return b;
	endfunction

	function automatic ip_addr_t mk_addr(logic fam, logic [63:0] hi, logic [63:0] lo);
		ip_addr_t a;
		a.fam = fam;
		a.hi  = hi;
		a.lo  = lo;
		return a;
	endfunction

	function automatic logic rand_fam();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic send_op(ipst_pkg::kind_t op, ip_addr_t a);
		int     gap;
		reply_t r;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid     = 1'b1;
		req_if.kind      = op;
		req_if.family    = a.fam;
		req_if.addr_high = a.hi;
		req_if.addr_low  = a.lo;
		do @(posedge clk); while (!req_if.ready);
		r = set_apply_op(op, a);
		pending_replies.push_back(r);
		ops_by_kind[op]++;
		replies_by_status[r.status]++;
		if (int'(r.total) > peak_total)
			peak_total = int'(r.total);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_ipv4_ops();
		ip_addr_t a;
		a = mk_addr(1'b0, '1, {32'hFFFF_FFFF, 32'h0A00_0001});
		send_op(ipst_pkg::KIND_LOOKUP, a);
		send_op(ipst_pkg::KIND_ADD, a);
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b0, '0, 64'h0A00_0001));
		send_op(ipst_pkg::KIND_LOOKUP,
			mk_addr(1'b0, 64'h1234_5678_9ABC_DEF0, 64'h5555_AAAA_0A00_0001));
		send_op(ipst_pkg::KIND_DELETE, mk_addr(1'b0, '0, 64'h0A00_0001));
		send_op(ipst_pkg::KIND_DELETE, a);
		send_op(ipst_pkg::KIND_LOOKUP, a);
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b0, '0, '0));
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b0, '0, 64'hFFFF_FFFF));
	endtask

	task automatic test_ipv6_ops();
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b1, '1, '1));
		// same bits as IPv4 0.0.0.0, other family: a separate entry
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b1, '0, '0));
		send_op(ipst_pkg::KIND_LOOKUP, mk_addr(1'b1, '0, '0));
		send_op(ipst_pkg::KIND_ADD, mk_addr(1'b1, '0, 64'h0A00_0001));
		send_op(ipst_pkg::KIND_LOOKUP, mk_addr(1'b0, '0, 64'h0A00_0001));
		send_op(ipst_pkg::KIND_DELETE, mk_addr(1'b1, '1, '1));
	endtask

	task automatic test_bucket_full();
		ip_addr_t way_addr[WAYS + 1];
		for (int i = 0; i <= WAYS; i++)
			way_addr[i] = addr_in_bucket(i[0], 8'h5A);
		for (int i = 0; i <= WAYS; i++)
			send_op(ipst_pkg::KIND_ADD, way_addr[i]);
		send_op(ipst_pkg::KIND_DELETE, scramble_unused(way_addr[1]));
		send_op(ipst_pkg::KIND_ADD, way_addr[WAYS]);
		send_op(ipst_pkg::KIND_ADD, way_addr[WAYS]);
		send_op(ipst_pkg::KIND_LOOKUP, way_addr[2]);
	endtask

	task automatic test_flush();
		ip_addr_t a;
		a = addr_in_bucket(1'b1, 8'h5A);
		send_op(ipst_pkg::KIND_FLUSH,
			mk_addr(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
		send_op(ipst_pkg::KIND_LOOKUP, mk_addr(1'b1, '1, '1));
		send_op(ipst_pkg::KIND_FLUSH, mk_addr(1'b0, '1, '1));
		send_op(ipst_pkg::KIND_ADD, a);
	endtask

	task automatic test_fill_table();
		ip_addr_t a;
		send_op(ipst_pkg::KIND_FLUSH, mk_addr(1'b0, '0, '0));
		filled_addrs.delete();
		for (int b = 0; b < NUM_BUCKETS; b++) begin
			burst_mode = (b < 64);
			for (int w = 0; w < WAYS; w++) begin
				a = addr_in_bucket(rand_fam(), b);
				filled_addrs.push_back(a);
				send_op(ipst_pkg::KIND_ADD, a);
			end
		end
		burst_mode = 1'b0;
		// table is full now: every new add must bounce
		for (int i = 0; i < 30; i++)
			send_op(ipst_pkg::KIND_ADD,
				addr_in_bucket(rand_fam(), int'($urandom_range(0, 255))));
		for (int i = 0; i < 30; i++)
			send_op(ipst_pkg::KIND_LOOKUP,
				scramble_unused(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]));
		for (int i = 0; i < 40; i++)
			send_op(ipst_pkg::KIND_DELETE,
				scramble_unused(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]));
		send_op(ipst_pkg::KIND_FLUSH,
			mk_addr(1'b1, {$urandom, $urandom}, {$urandom, $urandom}));
	endtask

	task automatic test_mixed_random();
		ip_addr_t        a;
		ipst_pkg::kind_t op;
		int              pick;
		int              src;
		recent_addrs.delete();
		for (int i = 0; i < 700; i++) begin
			if (i % 100 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			if (i == 350)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 45)
				op = ipst_pkg::KIND_ADD;
			else if (pick < 70)
				op = ipst_pkg::KIND_DELETE;
			else if (pick < 97)
				op = ipst_pkg::KIND_LOOKUP;
			else
				op = ipst_pkg::KIND_FLUSH;
			src = $urandom_range(0, 9);
			if (src < 6 && recent_addrs.size() != 0)
				a = scramble_unused(recent_addrs[$urandom_range(0, recent_addrs.size() - 1)]);
			else if (src < 8)
				a = addr_in_bucket(rand_fam(), int'($urandom_range(0, 7)));
			else
				a = mk_addr(rand_fam(), {$urandom, $urandom}, {$urandom, $urandom});
			if (op == ipst_pkg::KIND_ADD) begin
				recent_addrs.push_back(a);
				if (recent_addrs.size() > POOL_DEPTH)
					void'(recent_addrs.pop_front());
			end
			send_op(op, a);
		end
		burst_mode = 1'b0;
	endtask

	// response side: random stall per item
	initial begin
		rsp_if.ready = 1'b0;
		rsp_gap = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_gap > 0) begin
				rsp_if.ready = 1'b0;
				rsp_gap--;
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			rsp_gap = draw_gap();
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply status=%0d entry_total=%0d",
					$time, rsp_if.status, rsp_if.entry_total);
				error_count++;
			end else begin
				want = pending_replies.pop_front();
				if (rsp_if.status !== want.status) begin
					$display("%0t: status mismatch expected=%0d actual=%0d",
						$time, want.status, rsp_if.status);
					error_count++;
				end
				if (rsp_if.entry_total !== want.total) begin
					$display("%0t: entry_total mismatch expected=%0d actual=%0d",
						$time, want.total, rsp_if.entry_total);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d replies outstanding",
			$time, cycle_count, pending_replies.size());
		$display("tb_ip_address_set_table: FAIL");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.kind      = ipst_pkg::KIND_ADD;
		req_if.family    = 1'b0;
		req_if.addr_high = '0;
		req_if.addr_low  = '0;
		error_count      = 0;
		burst_mode       = 1'b0;
		live_total       = 0;
		peak_total       = 0;
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_ipv4_ops();
		test_ipv6_ops();
		test_bucket_full();
		test_flush();
		test_fill_table();
		test_mixed_random();

		wait_drained();
		repeat (10) @(posedge clk);
		if (pending_replies.size() != 0) begin
			$display("%0t: %0d replies never arrived", $time, pending_replies.size());
			error_count++;
		end
		$display("ops: %0d add, %0d delete, %0d lookup, %0d flush; peak entry count %0d",
			ops_by_kind[ipst_pkg::KIND_ADD], ops_by_kind[ipst_pkg::KIND_DELETE],
			ops_by_kind[ipst_pkg::KIND_LOOKUP], ops_by_kind[ipst_pkg::KIND_FLUSH],
			peak_total);
		$display("replies: %0d done, %0d present, %0d absent, %0d full; %0d errors",
			replies_by_status[ipst_pkg::STATUS_DONE],
			replies_by_status[ipst_pkg::STATUS_PRESENT],
			replies_by_status[ipst_pkg::STATUS_ABSENT],
			replies_by_status[ipst_pkg::STATUS_FULL], error_count);
		if (error_count == 0)
			$display("tb_ip_address_set_table: PASS");
		else
			$display("tb_ip_address_set_table: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ipst_pkg.sv
src/ipst_if.sv
src/ipst_ram.sv
src/ipst_ctrl.sv
src/ipst_datapath.sv
src/ip_address_set_table.sv
src/ipst_checker.sv
sim/tb_ip_address_set_table.sv
